// ----- rtl/core/mbba_pkg.sv -----
// Package for the multi-block bump allocator.
// Holds the item structs, the command and status codes and the register indexes.
// No dependencies.
`timescale 1ns / 1ps

package mbba_pkg;

  localparam int TYPE_W  = 3;
  localparam int FIELD_W = 40;
  localparam int LG_W    = 6;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 2;

  // Command kinds
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RST_OFF = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_TYPE   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_DONE      = 2'd3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_TYPE_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TYPE_FLAGS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DFLT_SIZE  = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_HV_MASK    = 2'd3;

  localparam logic [63:0] RESET_DFLT_SIZE = 64'd268435456;
  localparam logic [7:0]  RESET_HV_MASK   = 8'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         type_mask;
    logic [7:0]         required_flags;
    logic [FIELD_W-1:0] request_size;
    logic [LG_W-1:0]    align_log2;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         block_index;
    logic [FIELD_W-1:0] offset;
    logic [TYPE_W-1:0]  memory_type;
    logic               new_block;
    logic [FIELD_W-1:0] new_block_size;
    logic               host_visible;
  } out_item_t;

  // Control half of the scan token that walks the cell chain
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

  // Broadcast commands from the controller to every cell
  typedef struct packed {
    logic wr_en;
    logic clr_off;
  } cell_cmd_t;

endpackage

// ----- rtl/core/mbba_cell.sv -----
// One block table entry of the bump allocator plus one stage of the scan chain.
// Depends on mbba_pkg.
`timescale 1ns / 1ps

module mbba_cell import mbba_pkg::*; #(
  parameter int INDEX = 0,
  parameter int SW    = 40,
  parameter int IW    = 4,
  parameter int CW    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_cmd_t         cmd,
  input  logic [IW-1:0]     wr_idx,
  input  logic [SW-1:0]     wr_size,
  input  logic [SW-1:0]     wr_off,
  input  logic [TYPE_W-1:0] wr_type,
  input  logic              wr_vis,
  input  logic [CW-1:0]     count,
  input  tok_ctl_t          tin_ctl,
  input  logic [TYPE_W-1:0] tin_type,
  input  logic [SW-1:0]     tin_size,
  input  logic [LG_W-1:0]   tin_lg,
  input  logic [3:0]        tin_idx,
  input  logic [SW-1:0]     tin_off,
  input  logic              tin_vis,
  output tok_ctl_t          tout_ctl,
  output logic [TYPE_W-1:0] tout_type,
  output logic [SW-1:0]     tout_size,
  output logic [LG_W-1:0]   tout_lg,
  output logic [3:0]        tout_idx,
  output logic [SW-1:0]     tout_off,
  output logic              tout_vis
);

  logic [SW-1:0]     size_r;
  logic [SW-1:0]     off_r;
  logic [SW-1:0]     off_nxt;
  logic [TYPE_W-1:0] type_r;
  logic              vis_r;

  tok_ctl_t          ctl_r;
  logic [TYPE_W-1:0] type_tok_r;
  logic [SW-1:0]     size_tok_r;
  logic [LG_W-1:0]   lg_tok_r;
  logic [3:0]        idx_tok_r;
  logic [SW-1:0]     off_tok_r;
  logic              vis_tok_r;

  logic [63:0]       amask64;
  logic [SW:0]       amask;
  logic [SW:0]       al;
  logic [SW:0]       sum;
  logic              ok;
  logic              in_use;
  logic              hit;
  logic              wr_hit;

  assign in_use = CW'(INDEX) < count;
  assign wr_hit = cmd.wr_en && (wr_idx == IW'(INDEX));

  always_comb begin
    amask64 = (64'd1 << tin_lg) - 64'd1;
    amask   = {1'b0, amask64[SW-1:0]};
    if (32'(tin_lg) >= SW) begin
      // only a zero offset stays aligned
      ok = (off_r == '0);
      al = '0;
    end else begin
      ok = 1'b1;
      al = ({1'b0, off_r} + amask) & ~amask;
    end
    sum = al + {1'b0, tin_size};
    hit = tin_ctl.valid && !tin_ctl.found && in_use && (type_r == tin_type) && ok &&
          (sum <= {1'b0, size_r});
  end

  always_comb begin
    off_nxt = off_r;
    if (cmd.clr_off) begin
      off_nxt = '0;
    end else if (wr_hit) begin
      off_nxt = wr_off;
    end else if (hit) begin
      off_nxt = sum[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    if (wr_hit) begin
      size_r <= wr_size;
      type_r <= wr_type;
      vis_r  <= wr_vis;
    end
  end

  // advance the token one cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid <= tin_ctl.valid;
      ctl_r.found <= tin_ctl.found || hit;
    end
  end

  always_ff @(posedge clk) begin
    type_tok_r <= tin_type;
    size_tok_r <= tin_size;
    lg_tok_r   <= tin_lg;
    idx_tok_r  <= hit ? 4'(INDEX) : tin_idx;
    off_tok_r  <= hit ? al[SW-1:0] : tin_off;
    vis_tok_r  <= hit ? vis_r : tin_vis;
  end

  assign tout_ctl  = ctl_r;
  assign tout_type = type_tok_r;
  assign tout_size = size_tok_r;
  assign tout_lg   = lg_tok_r;
  assign tout_idx  = idx_tok_r;
  assign tout_off  = off_tok_r;
  assign tout_vis  = vis_tok_r;

endmodule

// ----- rtl/core/multi_block_bump_allocator.sv -----
// Top level of the multi-block bump allocator: type select, cell chain, result path.
// Depends on mbba_pkg and mbba_cell.
`timescale 1ns / 1ps

// Multi-block bump allocator. Each block table entry lives in a cell; an allocate
// item picks its memory type in the accept cycle, then a scan token walks the chain
// one cell per cycle and the first matching block that fits takes the allocation.
// A token that leaves the chain unserved appends a block at the tail if one is free.
// An allocate result passes each cell's token register, then the result and output
// registers; other items pass only those two. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted. The user must
// write configuration only while the block is idle; the block does not enforce it.
module multi_block_bump_allocator import mbba_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  parameter int NUM_TYPES  = 8,
  parameter int SIZE_BITS  = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int SW = SIZE_BITS;
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int TLIM = (NUM_TYPES < 8) ? NUM_TYPES : 8;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [3:0]        tcount_r;
  logic [63:0]       flags_r;
  logic [SW-1:0]     dflt_r;
  logic [7:0]        hv_r;
  logic              vis_new_r;

  logic              res_valid_r, res_valid_nxt;
  out_item_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r;
  logic              load;

  logic              accept;
  logic [3:0]        limit;
  logic              type_found;
  logic [TYPE_W-1:0] type_sel;
  logic              vis_sel;
  logic [7:0]        sel_flags;
  logic [63:0]       req64;
  logic [63:0]       cfg64;
  logic [SW-1:0]     size_in;

  cell_cmd_t         cmd;
  logic [SW-1:0]     wr_size;
  logic [SW-1:0]     bsize;
  logic [63:0]       off64;
  logic [63:0]       bsize64;

  tok_ctl_t          tok_ctl  [0:MAX_BLOCKS];
  logic [TYPE_W-1:0] tok_type [0:MAX_BLOCKS];
  logic [SW-1:0]     tok_size [0:MAX_BLOCKS];
  logic [LG_W-1:0]   tok_lg   [0:MAX_BLOCKS];
  logic [3:0]        tok_idx  [0:MAX_BLOCKS];
  logic [SW-1:0]     tok_off  [0:MAX_BLOCKS];
  logic              tok_vis  [0:MAX_BLOCKS];

  assign in_stall = (state_r != ST_IDLE) || res_valid_r;
  assign accept   = in_valid && !in_stall;
  assign req64    = {24'd0, in_data.request_size};
  assign size_in  = req64[SW-1:0];
  assign cfg64    = {24'd0, cfg_wdata[FIELD_W-1:0]};

  // lowest acceptable type whose flags cover the request
  always_comb begin
    limit      = (tcount_r > 4'(TLIM)) ? 4'(TLIM) : tcount_r;
    type_found = 1'b0;
    type_sel   = '0;
    for (int t = 0; t < 8; t++) begin
      if (!type_found && (4'(t) < limit) && in_data.type_mask[t] &&
          ((flags_r[8*t +: 8] & in_data.required_flags) == in_data.required_flags)) begin
        type_found = 1'b1;
        type_sel   = TYPE_W'(t);
      end
    end
    sel_flags = flags_r[8*type_sel +: 8];
    vis_sel   = |(sel_flags & hv_r);
  end

  // inject the scan token into the first cell
  always_comb begin
    tok_ctl[0].valid = accept && (in_data.kind == KIND_ALLOC) && type_found;
    tok_ctl[0].found = 1'b0;
    tok_type[0]      = type_sel;
    tok_size[0]      = size_in;
    tok_lg[0]        = in_data.align_log2;
    tok_idx[0]       = '0;
    tok_off[0]       = '0;
    tok_vis[0]       = 1'b0;
  end

  // tail of the chain: append a block when nothing fit
  always_comb begin
    bsize   = (tok_size[MAX_BLOCKS] > dflt_r) ? tok_size[MAX_BLOCKS] : dflt_r;
    wr_size = bsize;
    cmd.clr_off = accept && (in_data.kind == KIND_RST_OFF);
    cmd.wr_en   = tok_ctl[MAX_BLOCKS].valid && !tok_ctl[MAX_BLOCKS].found &&
                  (32'(count_r) < MAX_BLOCKS);
    off64   = 64'(tok_off[MAX_BLOCKS]);
    bsize64 = 64'(bsize);
  end

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    mbba_cell #(
      .INDEX(g),
      .SW   (SW),
      .IW   (IW),
      .CW   (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .wr_idx   (count_r[IW-1:0]),
      .wr_size  (wr_size),
      .wr_off   (tok_size[MAX_BLOCKS]),
      .wr_type  (tok_type[MAX_BLOCKS]),
      .wr_vis   (vis_new_r),
      .count    (count_r),
      .tin_ctl  (tok_ctl[g]),
      .tin_type (tok_type[g]),
      .tin_size (tok_size[g]),
      .tin_lg   (tok_lg[g]),
      .tin_idx  (tok_idx[g]),
      .tin_off  (tok_off[g]),
      .tin_vis  (tok_vis[g]),
      .tout_ctl (tok_ctl[g+1]),
      .tout_type(tok_type[g+1]),
      .tout_size(tok_size[g+1]),
      .tout_lg  (tok_lg[g+1]),
      .tout_idx (tok_idx[g+1]),
      .tout_off (tok_off[g+1]),
      .tout_vis (tok_vis[g+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !load;
    if (accept) begin
      res_nxt = '0;
      if (in_data.kind == KIND_ALLOC) begin
        if (type_found) begin
          state_nxt = ST_SCAN;
        end else begin
          res_nxt.status = ST_NO_TYPE;
          res_valid_nxt  = 1'b1;
        end
      end else begin
        if (in_data.kind == KIND_RELEASE) begin
          count_nxt = '0;
        end
        res_nxt.status = ST_DONE;
        res_valid_nxt  = 1'b1;
      end
    end
    if (state_r == ST_SCAN && tok_ctl[MAX_BLOCKS].valid) begin
      state_nxt           = ST_IDLE;
      res_valid_nxt       = 1'b1;
      res_nxt             = '0;
      res_nxt.memory_type = tok_type[MAX_BLOCKS];
      if (tok_ctl[MAX_BLOCKS].found) begin
        res_nxt.status       = ST_ALLOCATED;
        res_nxt.block_index  = tok_idx[MAX_BLOCKS];
        res_nxt.offset       = off64[FIELD_W-1:0];
        res_nxt.host_visible = tok_vis[MAX_BLOCKS];
      end else if (cmd.wr_en) begin
        res_nxt.status         = ST_ALLOCATED;
        res_nxt.block_index    = 4'(count_r);
        res_nxt.new_block      = 1'b1;
        res_nxt.new_block_size = bsize64[FIELD_W-1:0];
        res_nxt.host_visible   = vis_new_r;
        count_nxt              = count_r + CW'(1);
      end else begin
        res_nxt.status       = ST_FULL;
        res_nxt.host_visible = vis_new_r;
      end
    end
  end

  assign load          = res_valid_r && (!out_valid_r || !out_stall);
  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      tcount_r    <= '0;
      flags_r     <= '0;
      dflt_r      <= RESET_DFLT_SIZE[SW-1:0];
      hv_r        <= RESET_HV_MASK;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TYPE_COUNT: tcount_r <= cfg_wdata[3:0];
          CFG_TYPE_FLAGS: flags_r  <= cfg_wdata;
          CFG_DFLT_SIZE:  dflt_r   <= cfg64[SW-1:0];
          CFG_HV_MASK:    hv_r     <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (accept) begin
      vis_new_r <= vis_sel;
    end
    if (load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
